FILE: design/midpoint_line_rasterizer_top_macros.svh
// ----------------------------------------------------------------------------
// Midpoint line rasterizer assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_MACROS_SVH

// A property checked at every rising edge outside reset.
`define MLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define MLR_ASSERT_NEXT(label, ante, cons, msg) \
  `MLR_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: design/mlr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Item operation codes and fixed widths shared by the rasterizer files.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COLOR_BITS     = 24;
  localparam int ERR_GUARD_BITS = 5;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

endpackage

FILE: design/mlr_if.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer channels
// Valid/ready channels for command items and for pixel items.
// ----------------------------------------------------------------------------
interface mlr_item_if import mlr_pkg::*; #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  op_e                          operation;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic        [COLOR_BITS-1:0] line_color_in;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, line_color_in,
    input  ready
  );
  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, line_color_in,
    output ready
  );
endinterface

interface mlr_pixel_if import mlr_pkg::*; #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic        [COLOR_BITS-1:0] pixel_color;
  logic                         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

FILE: design/mlr_setup.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer setup
// Endpoint differences and major-axis ordering for both line orientations.
// ----------------------------------------------------------------------------
module mlr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic signed [COORD_BITS:0]   adx_o,
  output logic signed [COORD_BITS:0]   ady_o,
  output logic signed [COORD_BITS-1:0] sh_x0_o,
  output logic signed [COORD_BITS-1:0] sh_y0_o,
  output logic signed [COORD_BITS-1:0] sh_end_o,
  output logic signed [COORD_BITS:0]   sh_dy_o,
  output logic signed [COORD_BITS-1:0] st_x0_o,
  output logic signed [COORD_BITS-1:0] st_y0_o,
  output logic signed [COORD_BITS-1:0] st_end_o,
  output logic signed [COORD_BITS:0]   st_dx_o
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx_pos, dx_neg, dy_pos, dy_neg;
  logic                 sh_swap, st_swap;

  always_comb begin
    dx_pos = DW'(x_end_i) - DW'(x_start_i);
    dx_neg = DW'(x_start_i) - DW'(x_end_i);
    dy_pos = DW'(y_end_i) - DW'(y_start_i);
    dy_neg = DW'(y_start_i) - DW'(y_end_i);

    sh_swap = dx_pos[DW-1];
    st_swap = dy_pos[DW-1];

    adx_o = sh_swap ? dx_neg : dx_pos;
    ady_o = st_swap ? dy_neg : dy_pos;

    sh_x0_o  = sh_swap ? x_end_i   : x_start_i;
    sh_y0_o  = sh_swap ? y_end_i   : y_start_i;
    sh_end_o = sh_swap ? x_start_i : x_end_i;
    sh_dy_o  = sh_swap ? dy_neg    : dy_pos;

    st_x0_o  = st_swap ? x_end_i   : x_start_i;
    st_y0_o  = st_swap ? y_end_i   : y_start_i;
    st_end_o = st_swap ? y_start_i : y_end_i;
    st_dx_o  = st_swap ? dx_neg    : dx_pos;
  end

endmodule

FILE: design/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// While the pixel output is not held off, the block takes one item per clock
// and gives one pixel per clock on a stream of step items. A step item while
// a line is active passes through the setup register and then the result
// register, from which it is presented as a pixel. A start item occupies one
// slot and gives no pixel. The error-term update adds one increment and steps
// the major coordinate, and the minor one where needed, per clock, which
// allows one item per clock. The setup register between the input and that
// update does not limit the throughput. While a pixel waits, the block takes
// one more item into its setup register and then holds its input off.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top import mlr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlr_item_if.sink    item_i,
  mlr_pixel_if.source pixel_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + ERR_GUARD_BITS;

  // Setup stage.
  logic                         s1_valid_q, s1_valid_d;
  op_e                          s1_op_q;
  logic        [COLOR_BITS-1:0] s1_color_q;
  logic signed [DW-1:0]         adx_q, ady_q, sh_dy_q, st_dx_q;
  logic signed [COORD_BITS-1:0] sh_x0_q, sh_y0_q, sh_end_q;
  logic signed [COORD_BITS-1:0] st_x0_q, st_y0_q, st_end_q;
  logic signed [DW-1:0]         adx_d, ady_d, sh_dy_d, st_dx_d;
  logic signed [COORD_BITS-1:0] sh_x0_d, sh_y0_d, sh_end_d;
  logic signed [COORD_BITS-1:0] st_x0_d, st_y0_d, st_end_d;

  // Line state.
  logic                         busy_q, busy_d;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] major_end_q, major_end_d;
  logic signed [EW-1:0]         err_q, err_d, inc1_q, inc1_d, inc2_q, inc2_d;
  logic                         steep_q, steep_d, neg_q, neg_d;
  logic        [COLOR_BITS-1:0] color_q, color_d;

  // Result register.
  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic        [COLOR_BITS-1:0] out_color_q;
  logic                         out_last_q;

  logic                         exec_ready, in_fire, s1_fire, emit, is_last;
  logic                         new_steep, new_neg, cond, move_up, move_down;
  logic signed [EW-1:0]         dx_e, dy_e, dx2, dy2, new_err, new_inc1, new_inc2;
  logic signed [COORD_BITS-1:0] minor_step;

  mlr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_start_i (item_i.x_start),
    .y_start_i (item_i.y_start),
    .x_end_i   (item_i.x_end),
    .y_end_i   (item_i.y_end),
    .adx_o     (adx_d),
    .ady_o     (ady_d),
    .sh_x0_o   (sh_x0_d),
    .sh_y0_o   (sh_y0_d),
    .sh_end_o  (sh_end_d),
    .sh_dy_o   (sh_dy_d),
    .st_x0_o   (st_x0_d),
    .st_y0_o   (st_y0_d),
    .st_end_o  (st_end_d),
    .st_dx_o   (st_dx_d)
  );

  assign exec_ready   = !out_valid_q || pixel_o.ready;
  assign item_i.ready = !s1_valid_q || exec_ready;
  assign in_fire      = item_i.valid && item_i.ready;
  assign s1_fire      = s1_valid_q && exec_ready;
  assign emit         = s1_fire && (s1_op_q == OP_STEP) && busy_q;

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_x     = out_x_q;
  assign pixel_o.pixel_y     = out_y_q;
  assign pixel_o.pixel_color = out_color_q;
  assign pixel_o.last_pixel  = out_last_q;

  // Error term and increments for a new line.
  always_comb begin
    new_steep = ady_q > adx_q;
    dx_e      = EW'(new_steep ? st_dx_q : adx_q);
    dy_e      = EW'(new_steep ? ady_q : sh_dy_q);
    dx2       = dx_e <<< 1;
    dy2       = dy_e <<< 1;
    if (!new_steep) begin
      new_neg = dy_e[EW-1];
      if (!new_neg) begin
        new_err  = dx_e - dy2;
        new_inc1 = dx2 - dy2;
        new_inc2 = -dy2;
      end else begin
        new_err  = -dx_e - dy2;
        new_inc1 = -dy2;
        new_inc2 = -dx2 - dy2;
      end
    end else begin
      new_neg = dx_e[EW-1];
      if (!new_neg) begin
        new_err  = dx2 - dy_e;
        new_inc1 = dx2;
        new_inc2 = dx2 - dy2;
      end else begin
        new_err  = dx2 + dy_e;
        new_inc1 = dx2 + dy2;
        new_inc2 = dx2;
      end
    end
  end

  // One step along the active line.
  always_comb begin
    is_last   = steep_q ? (cur_y_q == major_end_q) : (cur_x_q == major_end_q);
    cond      = steep_q ? (!err_q[EW-1] && (err_q != '0)) : err_q[EW-1];
    move_up   = !neg_q && cond;
    move_down = neg_q && !cond;
    if (move_up) begin
      minor_step = COORD_BITS'(1);
    end else if (move_down) begin
      minor_step = '1;
    end else begin
      minor_step = '0;
    end
  end

  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = emit ? 1'b1 : (pixel_o.ready ? 1'b0 : out_valid_q);

    busy_d      = busy_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    major_end_d = major_end_q;
    err_d       = err_q;
    inc1_d      = inc1_q;
    inc2_d      = inc2_q;
    steep_d     = steep_q;
    neg_d       = neg_q;
    color_d     = color_q;

    if (s1_fire && (s1_op_q == OP_START)) begin
      busy_d      = 1'b1;
      steep_d     = new_steep;
      neg_d       = new_neg;
      err_d       = new_err;
      inc1_d      = new_inc1;
      inc2_d      = new_inc2;
      color_d     = s1_color_q;
      cur_x_d     = new_steep ? st_x0_q  : sh_x0_q;
      cur_y_d     = new_steep ? st_y0_q  : sh_y0_q;
      major_end_d = new_steep ? st_end_q : sh_end_q;
    end else if (emit) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        err_d = err_q + ((steep_q ? cond : !cond) ? inc2_q : inc1_q);
        if (steep_q) begin
          cur_y_d = cur_y_q + COORD_BITS'(1);
          cur_x_d = cur_x_q + minor_step;
        end else begin
          cur_x_d = cur_x_q + COORD_BITS'(1);
          cur_y_d = cur_y_q + minor_step;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      steep_q     <= 1'b0;
      neg_q       <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc1_q      <= '0;
      inc2_q      <= '0;
      color_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      steep_q     <= steep_d;
      neg_q       <= neg_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      major_end_q <= major_end_d;
      err_q       <= err_d;
      inc1_q      <= inc1_d;
      inc2_q      <= inc2_d;
      color_q     <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= item_i.operation;
      s1_color_q <= item_i.line_color_in;
      adx_q      <= adx_d;
      ady_q      <= ady_d;
      sh_x0_q    <= sh_x0_d;
      sh_y0_q    <= sh_y0_d;
      sh_end_q   <= sh_end_d;
      sh_dy_q    <= sh_dy_d;
      st_x0_q    <= st_x0_d;
      st_y0_q    <= st_y0_d;
      st_end_q   <= st_end_d;
      st_dx_q    <= st_dx_d;
    end
    if (emit) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_color_q <= color_q;
      out_last_q  <= is_last;
    end
  end

endmodule

FILE: design/mlr_checker.sv
// ----------------------------------------------------------------------------
// Midpoint line rasterizer checker
// Port-level assertions on the command and pixel channels.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_top_macros.svh"

module mlr_checker import mlr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] pixel_x_i,
  input logic signed [COORD_BITS-1:0] pixel_y_i,
  input logic        [COLOR_BITS-1:0] pixel_color_i,
  input logic                         last_pixel_i
);

  `MLR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "pixel dropped while stalled")
  `MLR_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(pixel_x_i) && $stable(pixel_y_i) && $stable(pixel_color_i) && $stable(last_pixel_i), "stalled pixel changed")
  `MLR_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i, "input blocked with empty output")
  `MLR_ASSERT_NEXT(a_backpressure, out_valid_i && !out_ready_i && in_valid_i && in_ready_i, !in_ready_i || out_ready_i, "setup stage overrun under stall")

endmodule

bind midpoint_line_rasterizer_top mlr_checker #(
  .COORD_BITS (COORD_BITS)
) u_mlr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (pixel_o.valid),
  .out_ready_i   (pixel_o.ready),
  .pixel_x_i     (pixel_o.pixel_x),
  .pixel_y_i     (pixel_o.pixel_y),
  .pixel_color_i (pixel_o.pixel_color),
  .last_pixel_i  (pixel_o.last_pixel)
);
